// ----- hdl/stw_pkg.sv -----
// ----------------------------------------------------------------------------
// stw_pkg: shared types and constants of the lap stopwatch
// Digit layout, band register indexes, reset values and cell control types.
// ----------------------------------------------------------------------------
package stw_pkg;

  // phase counter: wraps at TICKS_PER_PERIOD, time steps every STEP_DIV phases
  localparam int TICKS_PER_PERIOD = 61;
  localparam int PHASE_W          = $clog2(TICKS_PER_PERIOD + 1);
  localparam int STEP_DIV         = 6;
  localparam int SUB_W            = $clog2(STEP_DIV);
  localparam int STEP_LAST        = 60;

  // BCD digits: 0 tenths, 1 sec units, 2 sec tens, 3 min units, 4 min tens
  localparam int NUM_DIGITS = 5;
  localparam int DIGIT_W    = 4;
  localparam int DIGIT_SEC_TENS = 2;
  localparam int SEC_TENS_W = 3;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX [NUM_DIGITS] = '{
    4'd9, 4'd9, 4'd5, 4'd9, 4'd9
  };

  // band registers
  localparam int ADC_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LAP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LAP_CLEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_RESET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_SELECT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_RELEASE   = 3'd4;

  localparam logic [ADC_W-1:0] BAND_LAP_RST       = 10'h032;
  localparam logic [ADC_W-1:0] BAND_LAP_CLEAR_RST = 10'h0C3;
  localparam logic [ADC_W-1:0] BAND_RESET_RST     = 10'h17C;
  localparam logic [ADC_W-1:0] BAND_SELECT_RST    = 10'h22B;
  localparam logic [ADC_W-1:0] BAND_RELEASE_RST   = 10'h316;

  // request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADC  = 1'b1;

  typedef enum logic [2:0] {
    ACT_RELEASE,
    ACT_LAP,
    ACT_LAP_CLEAR,
    ACT_RESET,
    ACT_SELECT
  } stw_action_t;

  // lap cell control
  typedef struct packed {
    logic clr;
    logic load;
  } stw_lap_ctl_t;

endpackage

// ----- hdl/stw_time_cell.sv -----
// ----------------------------------------------------------------------------
// stw_time_cell: one BCD digit of the running time
// Counts on carry in, wraps at its own limit and passes carry to the next cell.
// ----------------------------------------------------------------------------
module stw_time_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic [stw_pkg::DIGIT_W-1:0]  digit_max,
  input  logic                         carry_in,
  output logic                         carry_out,
  output logic [stw_pkg::DIGIT_W-1:0]  digit
);
  import stw_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic               at_max;

  assign at_max    = (digit_r == digit_max);
  assign carry_out = carry_in & at_max;
  assign digit     = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (clr) begin
      digit_nxt = '0;
    end else if (carry_in) begin
      // wrap to zero past the limit
      digit_nxt = at_max ? '0 : digit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

// ----- hdl/stw_lap_cell.sv -----
// ----------------------------------------------------------------------------
// stw_lap_cell: one BCD digit of the captured lap
// Loads from its time cell on capture, clears on lap clear.
// ----------------------------------------------------------------------------
module stw_lap_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stw_pkg::stw_lap_ctl_t        ctl,
  input  logic [stw_pkg::DIGIT_W-1:0]  time_digit,
  output logic [stw_pkg::DIGIT_W-1:0]  digit
);
  import stw_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;

  assign digit = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.load) begin
      digit_nxt = time_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

// ----- hdl/stopwatch_with_lap.sv -----
// ----------------------------------------------------------------------------
// stopwatch_with_lap: BCD stopwatch MM:SS.t with lap capture
// Timer ticks advance the time, button-ladder ADC samples drive the controls.
// ----------------------------------------------------------------------------
// Each accepted request yields exactly one result: the time digits, the
// lap digits and the run flag as they stand after that request. A new
// request is taken every cycle while the result side keeps up; the result
// register is the only stage, so throughput is one request per cycle, and
// the carry through the row of five digit cells is combinational.
// A tick request (req_type 0) advances a phase counter while running; every
// sixth phase up to sixty the time steps one tenth, and 99:59.9 rolls over
// to 00:00.0. An ADC request (req_type 1) is sorted into a button band by the
// five band registers: below band_lap or at/above band_release is release
// (clear the ignore latch); then lap capture, lap clear, reset-and-pause and
// run/pause select. Lap capture and select act once per press: they are
// skipped while the ignore latch is set, and set it. Band registers must be
// written through the cfg_ port (index 0..4, others dropped) while idle; the
// block does not enforce this. After reset it runs at 00:00.0, default bands.
// ----------------------------------------------------------------------------
module stopwatch_with_lap (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [stw_pkg::ADC_W-1:0]       in_adc_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [stw_pkg::DIGIT_W-1:0]     out_time_tenths,
  output logic [stw_pkg::DIGIT_W-1:0]     out_time_sec_units,
  output logic [stw_pkg::SEC_TENS_W-1:0]  out_time_sec_tens,
  output logic [stw_pkg::DIGIT_W-1:0]     out_time_min_units,
  output logic [stw_pkg::DIGIT_W-1:0]     out_time_min_tens,
  output logic [stw_pkg::DIGIT_W-1:0]     out_lap_tenths,
  output logic [stw_pkg::DIGIT_W-1:0]     out_lap_sec_units,
  output logic [stw_pkg::SEC_TENS_W-1:0]  out_lap_sec_tens,
  output logic [stw_pkg::DIGIT_W-1:0]     out_lap_min_units,
  output logic [stw_pkg::DIGIT_W-1:0]     out_lap_min_tens,
  output logic                            out_running,
  // band register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stw_pkg::ADC_W-1:0]       cfg_data
);
  import stw_pkg::*;

  // band registers
  logic [ADC_W-1:0] band_lap_r, band_lap_clear_r, band_reset_r;
  logic [ADC_W-1:0] band_select_r, band_release_r;

  // control state
  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_inc;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic               run_r, run_nxt;
  logic               ignore_r, ignore_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               is_tick;
  logic               phase_wrap;
  logic               step;
  logic               time_clr;
  stw_action_t        action;
  stw_lap_ctl_t       lap_ctl;

  logic [NUM_DIGITS:0]  carry;
  logic [DIGIT_W-1:0]   time_digit [NUM_DIGITS];
  logic [DIGIT_W-1:0]   lap_digit  [NUM_DIGITS];

  // The result register is the state itself: state only moves on an accept,
  // and an accept needs no pending result, or one that leaves the same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_tick   = (in_req_type == REQ_TICK);
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Band registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_lap_r       <= BAND_LAP_RST;
      band_lap_clear_r <= BAND_LAP_CLEAR_RST;
      band_reset_r     <= BAND_RESET_RST;
      band_select_r    <= BAND_SELECT_RST;
      band_release_r   <= BAND_RELEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BAND_LAP:       band_lap_r       <= cfg_data;
        CFG_BAND_LAP_CLEAR: band_lap_clear_r <= cfg_data;
        CFG_BAND_RESET:     band_reset_r     <= cfg_data;
        CFG_BAND_SELECT:    band_select_r    <= cfg_data;
        CFG_BAND_RELEASE:   band_release_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Band decode: tested in ascending band order; anything unmatched, including
  // values that fall into empty bands, is a release.
  // --------------------------------------------------------------------------
  always_comb begin
    action = ACT_RELEASE;
    if (in_adc_value < band_lap_r) begin
      action = ACT_RELEASE;
    end else if (in_adc_value < band_lap_clear_r) begin
      action = ACT_LAP;
    end else if (in_adc_value >= band_lap_clear_r && in_adc_value < band_reset_r) begin
      action = ACT_LAP_CLEAR;
    end else if (in_adc_value >= band_reset_r && in_adc_value < band_select_r) begin
      action = ACT_RESET;
    end else if (in_adc_value >= band_select_r && in_adc_value < band_release_r) begin
      action = ACT_SELECT;
    end
  end

  // --------------------------------------------------------------------------
  // Phase counter with a mod-6 side counter: the side counter tracks
  // phase mod 6 and restarts with the phase, so it flags every sixth phase.
  // --------------------------------------------------------------------------
  assign phase_inc  = phase_r + 1'b1;
  assign phase_wrap = (phase_inc == PHASE_W'(TICKS_PER_PERIOD));

  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    step      = 1'b0;
    if (accept && is_tick && run_r) begin
      if (phase_wrap) begin
        phase_nxt = '0;
        sub_nxt   = '0;
      end else begin
        phase_nxt = phase_inc;
        sub_nxt   = (sub_r == SUB_W'(STEP_DIV - 1)) ? '0 : sub_r + 1'b1;
        // step the time on nonzero multiples of six up to sixty
        step      = (sub_nxt == '0) && (int'(phase_inc) <= STEP_LAST);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Button actions: run flag, ignore latch, time and lap control
  // --------------------------------------------------------------------------
  always_comb begin
    run_nxt      = run_r;
    ignore_nxt   = ignore_r;
    time_clr     = 1'b0;
    lap_ctl.clr  = 1'b0;
    lap_ctl.load = 1'b0;
    if (accept && !is_tick) begin
      case (action)
        ACT_RELEASE: begin
          ignore_nxt = 1'b0;
        end
        ACT_LAP: begin
          // capture once per press
          if (!ignore_r) begin
            lap_ctl.load = 1'b1;
            ignore_nxt   = 1'b1;
          end
        end
        ACT_LAP_CLEAR: begin
          lap_ctl.clr = 1'b1;
        end
        ACT_RESET: begin
          // zero the time and pause; phase is kept
          time_clr = 1'b1;
          run_nxt  = 1'b0;
        end
        ACT_SELECT: begin
          if (!ignore_r) begin
            run_nxt    = !run_r;
            ignore_nxt = 1'b1;
          end
        end
        default: begin
          ignore_nxt = 1'b0;
        end
      endcase
    end
  end

  // hold the result until taken, raise it on every accept
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      sub_r       <= '0;
      run_r       <= 1'b1;
      ignore_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      run_r       <= run_nxt;
      ignore_r    <= ignore_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Row of digit cells: the step enters at the tenths cell and the carry
  // ripples toward minutes tens; a carry out of the last cell means every
  // digit has just rolled to zero, which is the 99:59.9 wrap.
  // --------------------------------------------------------------------------
  assign carry[0] = step;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
    stw_time_cell u_time_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clr       (time_clr),
      .digit_max (DIGIT_MAX[i]),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .digit     (time_digit[i])
    );

    stw_lap_cell u_lap_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (lap_ctl),
      .time_digit (time_digit[i]),
      .digit      (lap_digit[i])
    );
  end

  // --------------------------------------------------------------------------
  // Result ports
  // --------------------------------------------------------------------------
  assign out_valid          = out_valid_r;
  assign out_time_tenths    = time_digit[0];
  assign out_time_sec_units = time_digit[1];
  assign out_time_sec_tens  = time_digit[DIGIT_SEC_TENS][SEC_TENS_W-1:0];
  assign out_time_min_units = time_digit[3];
  assign out_time_min_tens  = time_digit[4];
  assign out_lap_tenths     = lap_digit[0];
  assign out_lap_sec_units  = lap_digit[1];
  assign out_lap_sec_tens   = lap_digit[DIGIT_SEC_TENS][SEC_TENS_W-1:0];
  assign out_lap_min_units  = lap_digit[3];
  assign out_lap_min_tens   = lap_digit[4];
  assign out_running        = run_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the lap stopwatch
// Streams tick and button requests through a queue-fed driver, predicts every
// displayed time, lap and run flag, and checks each result field by field,
// across several band settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import stw_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 5000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS   = 110;   // random requests per band setting
  localparam int NUM_SETTINGS  = 10;
  localparam int FULL_PERIODS  = 2;     // tick periods in the burst run, a second each
  localparam int DRAIN_CYCLES  = 4;
  localparam int PRINT_CAP     = 30;

  typedef struct packed {
    logic             kind;
    logic [ADC_W-1:0] adc;
  } watch_req_t;

  typedef struct packed {
    logic [DIGIT_W-1:0]    tm_tenths;
    logic [DIGIT_W-1:0]    tm_sec_units;
    logic [SEC_TENS_W-1:0] tm_sec_tens;
    logic [DIGIT_W-1:0]    tm_min_units;
    logic [DIGIT_W-1:0]    tm_min_tens;
    logic [DIGIT_W-1:0]    lp_tenths;
    logic [DIGIT_W-1:0]    lp_sec_units;
    logic [SEC_TENS_W-1:0] lp_sec_tens;
    logic [DIGIT_W-1:0]    lp_min_units;
    logic [DIGIT_W-1:0]    lp_min_tens;
    logic                  run;
  } watch_view_t;

  // DUT port signals; the bench-driven ones are known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_TICK;
  logic [ADC_W-1:0]      in_adc_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIGIT_W-1:0]    out_time_tenths;
  logic [DIGIT_W-1:0]    out_time_sec_units;
  logic [SEC_TENS_W-1:0] out_time_sec_tens;
  logic [DIGIT_W-1:0]    out_time_min_units;
  logic [DIGIT_W-1:0]    out_time_min_tens;
  logic [DIGIT_W-1:0]    out_lap_tenths;
  logic [DIGIT_W-1:0]    out_lap_sec_units;
  logic [SEC_TENS_W-1:0] out_lap_sec_tens;
  logic [DIGIT_W-1:0]    out_lap_min_units;
  logic [DIGIT_W-1:0]    out_lap_min_tens;
  logic                  out_running;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BAND_LAP;
  logic [ADC_W-1:0]      cfg_data = '0;

  // requests waiting to go out (head stays queued until accepted) and the
  // displays they are predicted to produce
  watch_req_t  pending_reqs [$];
  watch_view_t expected_views [$];

  // shadow of the stopwatch
  logic [ADC_W-1:0]   lap_lo     = BAND_LAP_RST;
  logic [ADC_W-1:0]   clear_lo   = BAND_LAP_CLEAR_RST;
  logic [ADC_W-1:0]   reset_lo   = BAND_RESET_RST;
  logic [ADC_W-1:0]   select_lo  = BAND_SELECT_RST;
  logic [ADC_W-1:0]   release_lo = BAND_RELEASE_RST;
  logic [5:0]         tick_phase = '0;
  logic [DIGIT_W-1:0] clock_dig [NUM_DIGITS];
  logic [DIGIT_W-1:0] lap_dig   [NUM_DIGITS];
  logic               run_q    = 1'b1;
  logic               ignore_q = 1'b0;

  // idling control
  bit burst_on;        // no idling on either side while set
  int hold_asks;       // raised by the sequence, served by the receiver
  int hold_seen;
  int hold_left;
  int tx_gap, tx_calm;
  int rx_stall, rx_calm, rx_len;
  int quiet_cycles;
  int result_idx;
  int mismatches;

  stopwatch_with_lap u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_adc_value       (in_adc_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_time_tenths    (out_time_tenths),
    .out_time_sec_units (out_time_sec_units),
    .out_time_sec_tens  (out_time_sec_tens),
    .out_time_min_units (out_time_min_units),
    .out_time_min_tens  (out_time_min_tens),
    .out_lap_tenths     (out_lap_tenths),
    .out_lap_sec_units  (out_lap_sec_units),
    .out_lap_sec_tens   (out_lap_sec_tens),
    .out_lap_min_units  (out_lap_min_units),
    .out_lap_min_tens   (out_lap_min_tens),
    .out_running        (out_running),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sort an ADC reading into its button band. Bands are tried in ladder
  // order, so an empty or inverted band is never hit and falls to release.
  function automatic stw_action_t band_of(input logic [ADC_W-1:0] adc);
    if (adc < lap_lo)                          return ACT_RELEASE;
    if (adc >= lap_lo    && adc < clear_lo)    return ACT_LAP;
    if (adc >= clear_lo  && adc < reset_lo)    return ACT_LAP_CLEAR;
    if (adc >= reset_lo  && adc < select_lo)   return ACT_RESET;
    if (adc >= select_lo && adc < release_lo)  return ACT_SELECT;
    return ACT_RELEASE;
  endfunction

  // Apply one request to the shadow stopwatch and return the display after it.
  function automatic watch_view_t advance_watch(input watch_req_t rq);
    watch_view_t v;
    int          ph;
    int          i;
    if (rq.kind == REQ_TICK) begin
      // paused ticks leave everything alone, the phase included
      if (run_q) begin
        ph = (int'(tick_phase) + 1) % 64;
        if (ph >= TICKS_PER_PERIOD) ph = (ph - TICKS_PER_PERIOD) % 64;
        tick_phase = ph[5:0];
        if (ph != 0 && ph <= STEP_LAST && ph % STEP_DIV == 0) begin
          // ripple one tenth up through the digits; a carry out of the
          // minutes tens leaves every digit at zero (99:59.9 -> 00:00.0)
          clock_dig[0] = clock_dig[0] + 1'b1;
          for (i = 0; i < NUM_DIGITS; i++) begin
            if (clock_dig[i] > ((i == DIGIT_SEC_TENS) ? 5 : 9)) begin
              clock_dig[i] = '0;
              if (i < NUM_DIGITS - 1) clock_dig[i+1] = clock_dig[i+1] + 1'b1;
            end
          end
        end
      end
    end else begin
      case (band_of(rq.adc))
        ACT_LAP: begin
          if (!ignore_q) begin
            for (i = 0; i < NUM_DIGITS; i++) lap_dig[i] = clock_dig[i];
            ignore_q = 1'b1;
          end
        end
        ACT_LAP_CLEAR: begin
          for (i = 0; i < NUM_DIGITS; i++) lap_dig[i] = '0;
        end
        ACT_RESET: begin
          for (i = 0; i < NUM_DIGITS; i++) clock_dig[i] = '0;
          run_q = 1'b0;
        end
        ACT_SELECT: begin
          if (!ignore_q) begin
            run_q    = ~run_q;
            ignore_q = 1'b1;
          end
        end
        default: ignore_q = 1'b0;
      endcase
    end
    v.tm_tenths    = clock_dig[0];
    v.tm_sec_units = clock_dig[1];
    v.tm_sec_tens  = clock_dig[2][SEC_TENS_W-1:0];
    v.tm_min_units = clock_dig[3];
    v.tm_min_tens  = clock_dig[4];
    v.lp_tenths    = lap_dig[0];
    v.lp_sec_units = lap_dig[1];
    v.lp_sec_tens  = lap_dig[2][SEC_TENS_W-1:0];
    v.lp_min_units = lap_dig[3];
    v.lp_min_tens  = lap_dig[4];
    v.run          = run_q;
    return v;
  endfunction

  // Idle length for either side: mostly none, some short, a few long, and
  // now and then a calm stretch with no idling at all.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("ERROR: result %0d: %s is %0d, expected %0d", result_idx, what, got, want);
  endtask

  task automatic queue_req(input logic kind, input logic [ADC_W-1:0] adc);
    watch_req_t rq;
    rq.kind = kind;
    rq.adc  = adc;
    pending_reqs.push_back(rq);
  endtask

  // Random reading that lands in the wanted band; give up after a while when
  // the current setting leaves that band empty.
  function automatic logic [ADC_W-1:0] adc_for(input stw_action_t want);
    logic [ADC_W-1:0] v;
    int               n;
    v = 10'($urandom_range(0, 1023));
    for (n = 0; n < 200 && band_of(v) != want; n++) v = 10'($urandom_range(0, 1023));
    return v;
  endfunction

  // Reading on or just under one of the band bounds.
  function automatic logic [ADC_W-1:0] adc_on_bound();
    logic [ADC_W-1:0] b;
    case ($urandom_range(0, 4))
      0:       b = lap_lo;
      1:       b = clear_lo;
      2:       b = reset_lo;
      3:       b = select_lo;
      default: b = release_lo;
    endcase
    if (b != 0 && $urandom_range(0, 1)) b = b - 1'b1;
    return b;
  endfunction

  // Mostly runs of ticks and clean presses (hold a button, then let go),
  // with some lone readings as noise.
  task automatic gen_requests(input int count);
    int          made;
    int          r;
    int          k;
    stw_action_t act;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        for (k = $urandom_range(1, 12); k > 0; k--) begin
          queue_req(REQ_TICK, 10'($urandom_range(0, 1023)));
          made++;
        end
      end else if (r < 85) begin
        act = stw_action_t'($urandom_range(int'(ACT_LAP), int'(ACT_SELECT)));
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          queue_req(REQ_ADC, adc_for(act));
          made++;
        end
        for (k = $urandom_range(1, 2); k > 0; k--) begin
          queue_req(REQ_ADC, adc_for(ACT_RELEASE));
          made++;
        end
      end else begin
        queue_req(REQ_ADC, $urandom_range(0, 1) ? adc_on_bound() : 10'($urandom_range(0, 1023)));
        made++;
      end
    end
  endtask

  // Hold the sender until every queued request has been answered.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_views.size() != 0) @(posedge clk);
  endtask

  // One band register write; keep the shadow copy in step. Spare indexes
  // are dropped by the block and by the shadow alike.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADC_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BAND_LAP:       lap_lo     = val;
      CFG_BAND_LAP_CLEAR: clear_lo   = val;
      CFG_BAND_RESET:     reset_lo   = val;
      CFG_BAND_SELECT:    select_lo  = val;
      CFG_BAND_RELEASE:   release_lo = val;
      default: ;
    endcase
  endtask

  task automatic write_bands(input logic [ADC_W-1:0] b_lap, b_clear, b_reset, b_select,
                             b_release);
    int spare;
    spare = int'(CFG_BAND_RELEASE) +
            $urandom_range(1, (1 << CFG_IDX_W) - 1 - int'(CFG_BAND_RELEASE));
    write_reg(CFG_BAND_LAP, b_lap);
    write_reg(CFG_BAND_LAP_CLEAR, b_clear);
    write_reg(spare[CFG_IDX_W-1:0], 10'($urandom_range(0, 1023)));
    write_reg(CFG_BAND_RESET, b_reset);
    write_reg(CFG_BAND_SELECT, b_select);
    write_reg(CFG_BAND_RELEASE, b_release);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: offer the head of the queue, drop it on acceptance and
  // predict its display at that same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_views.push_back(advance_watch(pending_reqs[0]));
        pending_reqs.pop_front();
        tx_gap = burst_on ? 0 : idle_len(tx_calm);
      end
      // a new request may go out only once the current one is gone
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid     <= 1'b1;
          in_req_type  <= pending_reqs[0].kind;
          in_adc_value <= pending_reqs[0].adc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted display against the oldest
  // prediction, then pick the next ready level.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected result, count waiting", 0, 0);
        end else begin
          if (out_time_tenths !== expected_views[0].tm_tenths)
            report_mismatch("time_tenths", int'(out_time_tenths),
                            int'(expected_views[0].tm_tenths));
          if (out_time_sec_units !== expected_views[0].tm_sec_units)
            report_mismatch("time_sec_units", int'(out_time_sec_units),
                            int'(expected_views[0].tm_sec_units));
          if (out_time_sec_tens !== expected_views[0].tm_sec_tens)
            report_mismatch("time_sec_tens", int'(out_time_sec_tens),
                            int'(expected_views[0].tm_sec_tens));
          if (out_time_min_units !== expected_views[0].tm_min_units)
            report_mismatch("time_min_units", int'(out_time_min_units),
                            int'(expected_views[0].tm_min_units));
          if (out_time_min_tens !== expected_views[0].tm_min_tens)
            report_mismatch("time_min_tens", int'(out_time_min_tens),
                            int'(expected_views[0].tm_min_tens));
          if (out_lap_tenths !== expected_views[0].lp_tenths)
            report_mismatch("lap_tenths", int'(out_lap_tenths),
                            int'(expected_views[0].lp_tenths));
          if (out_lap_sec_units !== expected_views[0].lp_sec_units)
            report_mismatch("lap_sec_units", int'(out_lap_sec_units),
                            int'(expected_views[0].lp_sec_units));
          if (out_lap_sec_tens !== expected_views[0].lp_sec_tens)
            report_mismatch("lap_sec_tens", int'(out_lap_sec_tens),
                            int'(expected_views[0].lp_sec_tens));
          if (out_lap_min_units !== expected_views[0].lp_min_units)
            report_mismatch("lap_min_units", int'(out_lap_min_units),
                            int'(expected_views[0].lp_min_units));
          if (out_lap_min_tens !== expected_views[0].lp_min_tens)
            report_mismatch("lap_min_tens", int'(out_lap_min_tens),
                            int'(expected_views[0].lp_min_tens));
          if (out_running !== expected_views[0].run)
            report_mismatch("running", int'(out_running), int'(expected_views[0].run));
          expected_views.pop_front();
        end
        result_idx++;
      end
      // a requested hold-off wins over everything and is counted here
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
        hold_seen++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (burst_on) begin
        out_ready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        rx_len   = idle_len(rx_calm);
        rx_stall = (rx_len > 0) ? rx_len - 1 : 0;
        out_ready <= (rx_len == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no channel has moved for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int          p;
    int          k;
    int          a0, a1, a2, a3, a4;
    for (k = 0; k < NUM_DIGITS; k++) begin
      clock_dig[k] = '0;
      lap_dig[k]   = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with the reset bands, starting at 00:00.0 and running.
    // Step six ticks so the first tenth lands on phase six.
    for (k = 0; k < STEP_DIV; k++) queue_req(REQ_TICK, k[0] ? '1 : '0);
    queue_req(REQ_ADC, 10'd1023);                  // top of the ladder: release
    queue_req(REQ_ADC, 10'd0);                     // bottom of the ladder: release
    queue_req(REQ_ADC, BAND_LAP_RST);              // lap captures 00:00.1, latches
    queue_req(REQ_ADC, BAND_LAP_CLEAR_RST - 10'd1); // lap held: ignored while latched
    queue_req(REQ_ADC, BAND_LAP_RST - 10'd1);      // just under lap: release
    queue_req(REQ_ADC, BAND_LAP_CLEAR_RST);        // lap clear
    queue_req(REQ_ADC, BAND_RESET_RST - 10'd1);    // lap clear again, latch untouched
    queue_req(REQ_ADC, BAND_SELECT_RST);           // select pauses, latches
    queue_req(REQ_ADC, BAND_RELEASE_RST - 10'd1);  // select held: ignored
    queue_req(REQ_TICK, '0);                       // paused tick changes nothing
    queue_req(REQ_ADC, BAND_RELEASE_RST);          // release bound itself
    queue_req(REQ_ADC, BAND_SELECT_RST - 10'd1);   // reset zeroes time and pauses
    queue_req(REQ_ADC, BAND_RESET_RST);            // reset again while paused
    queue_req(REQ_ADC, 10'd600);                   // select: run again
    queue_req(REQ_ADC, 10'd49);                    // release
    queue_req(REQ_ADC, BAND_LAP_RST);              // lap at 00:00.0
    queue_req(REQ_TICK, '1);
    wait_idle();

    // Back-to-back run with no idling: reset, start, then a couple of
    // seconds of ticks so the tenths carry into the seconds.
    burst_on = 1'b1;
    queue_req(REQ_ADC, 10'd400);
    queue_req(REQ_ADC, 10'd900);
    queue_req(REQ_ADC, 10'd600);
    queue_req(REQ_ADC, 10'd900);
    for (k = 0; k < TICKS_PER_PERIOD * FULL_PERIODS; k++)
      queue_req(REQ_TICK, 10'($urandom_range(0, 1023)));
    wait_idle();
    burst_on = 1'b0;

    // Random phases, one band setting each. Every phase pauses the sender
    // halfway until all results are in; bands change only while idle.
    for (p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: ;  // reset bands
        1, 8: begin
          a0 = $urandom_range(1, 150);
          a1 = a0 + $urandom_range(1, 200);
          a2 = a1 + $urandom_range(1, 200);
          a3 = a2 + $urandom_range(1, 200);
          a4 = a3 + $urandom_range(1, 1023 - a3);
          write_bands(10'(a0), 10'(a1), 10'(a2), 10'(a3), 10'(a4));
        end
        2: write_bands(10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        3: write_bands(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        4: write_bands(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        5: write_bands(10'd900, 10'd700, 10'd500, 10'd300, 10'd100);
        6: write_bands(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                       10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                       10'($urandom_range(0, 1023)));
        7: write_bands(10'd10, 10'd11, 10'd12, 10'd13, 10'd14);
        default: write_bands(BAND_LAP_RST, BAND_LAP_CLEAR_RST, BAND_RESET_RST,
                             BAND_SELECT_RST, BAND_RELEASE_RST);
      endcase
      gen_requests(PHASE_ITEMS / 2);
      // first phase: starve the result side while requests keep coming,
      // so the result stage fills and the request side backs up
      if (p == 0) hold_asks++;
      wait_idle();
      gen_requests(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch("results never delivered", 0, expected_views.size());
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- stopwatch_with_lap.f -----
hdl/stw_pkg.sv
hdl/stw_time_cell.sv
hdl/stw_lap_cell.sv
hdl/stopwatch_with_lap.sv
tb/tb.sv
